// ===== rtl/rrhts_pkg.sv =====
// ============================================================================
// rrhts_pkg
// Shared types and command codes for the round-robin healthy target selector.
// ============================================================================
`default_nettype none

package rrhts_pkg;

    // Command codes carried in an input transaction.
    localparam logic [1:0] CMD_ACQUIRE   = 2'd0;
    localparam logic [1:0] CMD_MARK_DOWN = 2'd1;
    localparam logic [1:0] CMD_MARK_UP   = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [1:0] command;
        logic [3:0] target_index;
    } t_cmd_item;

    // Result transaction payload.
    typedef struct packed {
        logic       granted;
        logic [3:0] chosen_index;
        logic [4:0] healthy_total;
        logic       target_present;
    } t_res_item;

    // Configuration write payload.
    typedef struct packed {
        logic [4:0] num_targets;
    } t_cfg_item;

    // Status returned by the scan unit to the sequencer.
    typedef struct packed {
        logic done;
        logic found;
    } t_scan_stat;

endpackage

`default_nettype wire

// ===== rtl/rrhts_cfg_if.sv =====
// ============================================================================
// rrhts_cfg_if
// Configuration write channel carrying the target count.
// ============================================================================
`default_nettype none

interface rrhts_cfg_if;
    logic                 valid;
    logic                 ready;
    rrhts_pkg::t_cfg_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrhts_cmd_if.sv =====
// ============================================================================
// rrhts_cmd_if
// Command channel carrying one acquire or mark transaction.
// ============================================================================
`default_nettype none

interface rrhts_cmd_if;
    logic                 valid;
    logic                 ready;
    rrhts_pkg::t_cmd_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrhts_res_if.sv =====
// ============================================================================
// rrhts_res_if
// Result channel carrying one result transaction per command.
// ============================================================================
`default_nettype none

interface rrhts_res_if;
    logic                 valid;
    logic                 ready;
    rrhts_pkg::t_res_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/rrhts_scan_unit.sv =====
// ============================================================================
// rrhts_scan_unit
// Circular scan over the health vector, one target per cycle. Starting at a
// given position it visits every target once, records the first healthy one
// and counts all healthy ones.
// ============================================================================
`default_nettype none

module rrhts_scan_unit #(
    parameter int MAX_TARGETS = 16,
    localparam int PW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1,
    localparam int CW = $clog2(MAX_TARGETS + 1)
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_go,
    input  wire logic [PW-1:0]          i_start,
    input  wire logic [CW-1:0]          i_count,
    input  wire logic [MAX_TARGETS-1:0] i_health,
    output rrhts_pkg::t_scan_stat       o_stat,
    output logic      [PW-1:0]          o_chosen,
    output logic      [CW-1:0]          o_total
);
    import rrhts_pkg::*;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [PW-1:0] r_pos, n_pos;
    logic [CW-1:0] r_step, n_step;
    logic          r_found, n_found;
    logic [PW-1:0] r_chosen, n_chosen;
    logic [CW-1:0] r_total, n_total;

    logic          w_bit;
    logic          w_last;
    logic          w_wrap;

    // Current target's health and position checks.
    assign w_bit  = i_health[r_pos];
    assign w_last = (r_step == i_count - CW'(1));
    assign w_wrap = (CW'(r_pos) == i_count - CW'(1));

    // One scan step per cycle while busy.
    always_comb begin
        n_busy   = r_busy;
        n_done   = 1'b0;
        n_pos    = r_pos;
        n_step   = r_step;
        n_found  = r_found;
        n_chosen = r_chosen;
        n_total  = r_total;
        if (i_go) begin
            n_busy  = 1'b1;
            n_pos   = i_start;
            n_step  = '0;
            n_found = 1'b0;
            n_total = '0;
        end else if (r_busy) begin
            if (w_bit) begin
                n_total = r_total + CW'(1);
                if (!r_found) begin
                    n_found  = 1'b1;
                    n_chosen = r_pos;
                end
            end
            n_pos  = w_wrap ? '0 : r_pos + PW'(1);
            n_step = r_step + CW'(1);
            if (w_last) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    // Scan working registers.
    always_ff @(posedge i_clk) begin
        r_pos    <= n_pos;
        r_step   <= n_step;
        r_found  <= n_found;
        r_chosen <= n_chosen;
        r_total  <= n_total;
    end

    assign o_stat.done  = r_done;
    assign o_stat.found = r_found;
    assign o_chosen     = r_chosen;
    assign o_total      = r_total;

endmodule

`default_nettype wire

// ===== rtl/round_robin_healthy_target_select_core.sv =====
// ============================================================================
// round_robin_healthy_target_select_core
// Round-robin selector over a pool of targets with one health bit each.
// ============================================================================
//
// Usage:
//   i_cfg writes the target count (0 acts as 1, values above MAX_TARGETS
//   saturate). Write it only while no command is in flight.
//   i_cmd takes one command transaction: acquire, mark down or mark up.
//   o_res returns exactly one result transaction per command, in order.
//
// Sequencing:
//   With N the effective target count, the scan unit visits one target per
//   cycle over N targets; the sequencer then moves from S_SCAN to S_RESULT,
//   where the registered result is offered. One command is handled at a time;
//   the next is accepted at the earliest in the cycle after the result is taken.
//
// Reset: all targets healthy, round-robin pointer at 0, target count 1.
// A stalled receiver holds the result in its output register; i_cmd stays
// not ready until that result is taken.
// ============================================================================
`default_nettype none

module round_robin_healthy_target_select_core #(
    parameter int MAX_TARGETS = 16
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    rrhts_cfg_if.sink    i_cfg,
    rrhts_cmd_if.sink    i_cmd,
    rrhts_res_if.source  o_res
);
    import rrhts_pkg::*;

    localparam int PW   = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
    localparam int CW   = $clog2(MAX_TARGETS + 1);
    localparam int CMPW = (CW > 4) ? CW : 4;

    // Sequencer states.
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_RESULT = 2'd2;

    logic [1:0]             r_state, n_state;
    logic [MAX_TARGETS-1:0] r_health, n_health;
    logic [PW-1:0]          r_ptr, n_ptr;
    logic [CW-1:0]          r_n, n_n;
    logic                   r_is_acq, n_is_acq;
    logic                   r_present, n_present;
    t_res_item              r_res, n_res;

    logic                   w_accept;
    logic                   w_present;
    logic [PW-1:0]          w_start;
    logic [CW-1:0]          w_inc;
    logic [PW-1:0]          w_scan_start;
    t_scan_stat             w_stat;
    logic [PW-1:0]          w_chosen;
    logic [CW-1:0]          w_total;

    assign i_cfg.ready = 1'b1;
    assign i_cmd.ready = (r_state == S_IDLE);
    assign w_accept    = i_cmd.valid && i_cmd.ready;

    // Presence and round-robin start for the incoming command.
    assign w_present = CMPW'(i_cmd.payload.target_index) < CMPW'(r_n);
    assign w_start   = (CW'(r_ptr) < r_n) ? r_ptr : '0;
    assign w_inc     = CW'(w_start) + CW'(1);
    assign w_scan_start = (i_cmd.payload.command == CMD_ACQUIRE) ? w_start : '0;

    // Shared scan unit: finds the first healthy target and counts healthy ones.
    rrhts_scan_unit #(
        .MAX_TARGETS (MAX_TARGETS)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (w_accept),
        .i_start  (w_scan_start),
        .i_count  (r_n),
        .i_health (r_health),
        .o_stat   (w_stat),
        .o_chosen (w_chosen),
        .o_total  (w_total)
    );

    // Configuration: store the effective target count.
    always_comb begin
        n_n = r_n;
        if (i_cfg.valid && i_cfg.ready) begin
            if (i_cfg.payload.num_targets == 5'd0) begin
                n_n = CW'(1);
            end else if (32'(i_cfg.payload.num_targets) > 32'(MAX_TARGETS)) begin
                n_n = CW'(MAX_TARGETS);
            end else begin
                n_n = CW'(i_cfg.payload.num_targets);
            end
        end
    end

    // Sequencer, health update and pointer advance.
    always_comb begin
        n_state   = r_state;
        n_health  = r_health;
        n_ptr     = r_ptr;
        n_is_acq  = r_is_acq;
        n_present = r_present;
        n_res     = r_res;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state   = S_SCAN;
                    n_is_acq  = (i_cmd.payload.command == CMD_ACQUIRE);
                    n_present = w_present;
                    case (i_cmd.payload.command)
                        CMD_ACQUIRE: begin
                            n_ptr = (w_inc == r_n) ? '0 : PW'(w_inc);
                        end
                        CMD_MARK_DOWN: begin
                            if (w_present) begin
                                n_health[PW'(i_cmd.payload.target_index)] = 1'b0;
                            end
                        end
                        CMD_MARK_UP: begin
                            if (w_present) begin
                                n_health[PW'(i_cmd.payload.target_index)] = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (w_stat.done) begin
                    n_state                = S_RESULT;
                    n_res.granted          = r_is_acq && w_stat.found;
                    n_res.chosen_index     = (r_is_acq && w_stat.found) ? 4'(w_chosen) : 4'd0;
                    n_res.healthy_total    = 5'(w_total);
                    n_res.target_present   = r_present;
                end
            end
            S_RESULT: begin
                if (o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_health <= '1;
            r_ptr    <= '0;
            r_n      <= CW'(1);
        end else begin
            r_state  <= n_state;
            r_health <= n_health;
            r_ptr    <= n_ptr;
            r_n      <= n_n;
        end
    end

    // Command attributes and the result register.
    always_ff @(posedge i_clk) begin
        r_is_acq  <= n_is_acq;
        r_present <= n_present;
        r_res     <= n_res;
    end

    assign o_res.valid   = (r_state == S_RESULT);
    assign o_res.payload = r_res;

    // A result without a grant always reports target zero.
    a_chosen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && !o_res.payload.granted |-> o_res.payload.chosen_index == 4'd0)
        else $error("chosen_index nonzero without a grant");

    // The healthy total never exceeds the effective target count.
    a_total_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> 32'(o_res.payload.healthy_total) <= 32'(r_n))
        else $error("healthy_total above target count");

    // The scan unit finishes only while the sequencer waits for it.
    a_done_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> r_state == S_SCAN)
        else $error("scan finished outside the scan state");

    // An accepted command always leads into the scan state.
    a_accept_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_SCAN)
        else $error("accepted command did not start a scan");

endmodule

`default_nettype wire

// ===== tb/sv/target_select_checker.sv =====
`timescale 1ns / 1ps
// ============================================================================
// target_select_checker
// Watches the configuration, command and result channels of the round-robin
// healthy target selector. Every accepted command is run through a local
// model of the health mask and the round-robin pointer. The predicted result
// is queued and compared field by field with the next accepted result.
// ============================================================================

module target_select_checker #(
    parameter int MAX_TARGETS = 16
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    rrhts_cfg_if  i_cfg,
    rrhts_cmd_if  i_cmd,
    rrhts_res_if  i_res,
    output int    o_fail_count,
    output int    o_outstanding
);
    import rrhts_pkg::*;

    // Local copy of the selector state and its register.
    logic [15:0] health_mask;
    logic [3:0]  rr_pointer;
    logic [4:0]  pool_size_reg;

    // Results predicted for accepted commands, oldest first.
    t_res_item   predicted_results[$];
    int          fail_total;

    initial begin
        o_fail_count  = 0;
        o_outstanding = 0;
        fail_total    = 0;
    end

    // Applies one command to the local state and returns the result it causes.
    function automatic t_res_item select_target(t_cmd_item item);
        int unsigned pool;
        int unsigned first;
        int unsigned slot;
        int unsigned healthy;
        t_res_item   res;
        if (pool_size_reg == 0) begin
            pool = 1;
        end else if (pool_size_reg > MAX_TARGETS) begin
            pool = MAX_TARGETS;
        end else begin
            pool = pool_size_reg;
        end
        res = '0;
        res.target_present = (item.target_index < pool);
        healthy = 0;
        case (item.command)
            CMD_ACQUIRE: begin
                // A stale pointer beyond the pool restarts the scan at target zero.
                first = (rr_pointer < pool) ? rr_pointer : 0;
                rr_pointer = 4'((first + 1) % pool);
                for (int i = 0; i < pool; i++) begin
                    slot = (first + i) % pool;
                    if (!res.granted && health_mask[slot]) begin
                        res.granted      = 1'b1;
                        res.chosen_index = 4'(slot);
                    end
                end
            end
            CMD_MARK_DOWN: begin
                if (res.target_present) begin
                    health_mask[item.target_index] = 1'b0;
                end
            end
            CMD_MARK_UP: begin
                if (res.target_present) begin
                    health_mask[item.target_index] = 1'b1;
                end
            end
            default: begin
                // Reserved command code leaves the state alone.
            end
        endcase
        for (int i = 0; i < pool; i++) begin
            if (health_mask[i]) begin
                healthy++;
            end
        end
        res.healthy_total = 5'(healthy);
        return res;
    endfunction

    // Sample every channel at the clock edge and keep the scoreboard in order.
    always @(posedge i_clk) begin
        t_res_item want;
        t_res_item got;
        if (!i_rst_n) begin
            health_mask   = '1;
            rr_pointer    = '0;
            pool_size_reg = 5'd1;
            predicted_results.delete();
        end else begin
            if (i_res.valid && i_res.ready) begin
                got = i_res.payload;
                if (predicted_results.size() == 0) begin
                    fail_total++;
                    if (fail_total <= 10) begin
                        $display("%0t: result transaction with none expected: g=%0d idx=%0d total=%0d present=%0d",
                                 $realtime, got.granted, got.chosen_index,
                                 got.healthy_total, got.target_present);
                    end
                end else begin
                    want = predicted_results.pop_front();
                    if (got.granted !== want.granted
                            || got.chosen_index !== want.chosen_index
                            || got.healthy_total !== want.healthy_total
                            || got.target_present !== want.target_present) begin
                        fail_total++;
                        if (fail_total <= 10) begin
                            $display("%0t: result mismatch: expected g=%0d idx=%0d total=%0d present=%0d, got g=%0d idx=%0d total=%0d present=%0d",
                                     $realtime, want.granted, want.chosen_index,
                                     want.healthy_total, want.target_present,
                                     got.granted, got.chosen_index,
                                     got.healthy_total, got.target_present);
                        end
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                pool_size_reg = i_cfg.payload.num_targets;
            end
            if (i_cmd.valid && i_cmd.ready) begin
                predicted_results.push_back(select_target(i_cmd.payload));
            end
        end
        o_outstanding <= predicted_results.size();
        o_fail_count  <= fail_total;
    end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus and verdict for the round-robin healthy target selector.
// A directed run covers pool-size extremes, every command, a stale pointer,
// marks on missing targets and an empty pool; random commands follow under
// four idling patterns and several pool sizes, while the checker scores them.
// ============================================================================

module tb;
    import rrhts_pkg::*;

    localparam int          MAX_TARGETS  = 16;
    localparam logic [1:0]  CMD_RESERVED = 2'd3;
    localparam int unsigned TIMEOUT_NS   = 5_000_000;
    localparam int          SETTINGS_PER_PHASE = 5;
    localparam int          CMDS_PER_SETTING   = 88;

    // Idling pattern per phase: sender idle and receiver stall, in percent.
    localparam int SEND_IDLE_PCT  [4] = '{0, 47, 0, 21};
    localparam int RECV_STALL_PCT [4] = '{0, 0, 47, 21};

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    logic res_ready = 1'b0;

    int fail_count;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int pool_eff       = 1;
    int cmds_sent      = 0;

    rrhts_cfg_if cfg_bus ();
    rrhts_cmd_if cmd_bus ();
    rrhts_res_if res_bus ();

    assign res_bus.ready = res_ready;

    round_robin_healthy_target_select_core #(
        .MAX_TARGETS (MAX_TARGETS)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cfg   (cfg_bus),
        .i_cmd   (cmd_bus),
        .o_res   (res_bus)
    );

    target_select_checker #(
        .MAX_TARGETS (MAX_TARGETS)
    ) checker_inst (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg         (cfg_bus),
        .i_cmd         (cmd_bus),
        .i_res         (res_bus),
        .o_fail_count  (fail_count),
        .o_outstanding (outstanding)
    );

    // Clock: 8 ns period.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Result receiver stalls at random according to the current phase.
    always @(posedge clk) begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Hard limit on the run.
    initial begin
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // Presents one command transaction and returns at the edge it is taken.
    task automatic issue_command(logic [1:0] cmd, logic [3:0] idx);
        while ($urandom_range(99) < send_idle_pct) begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid                <= 1'b1;
        cmd_bus.payload.command      <= cmd;
        cmd_bus.payload.target_index <= idx;
        do @(posedge clk); while (!cmd_bus.ready);
        cmds_sent++;
    endtask

    // Holds off new commands until every outstanding result has come back.
    task automatic drain_results();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    // Rewrites the pool size once the selector is idle.
    task automatic write_pool_size(logic [4:0] value);
        drain_results();
        cfg_bus.valid               <= 1'b1;
        cfg_bus.payload.num_targets <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        if (value == 0) begin
            pool_eff = 1;
        end else if (value > MAX_TARGETS) begin
            pool_eff = MAX_TARGETS;
        end else begin
            pool_eff = value;
        end
    endtask

    // One random command, mostly aimed at targets inside the pool.
    task automatic random_command();
        int          pick;
        logic [1:0]  cmd;
        logic [3:0]  idx;
        pick = $urandom_range(99);
        if (pick < 45) begin
            cmd = CMD_ACQUIRE;
        end else if (pick < 70) begin
            cmd = CMD_MARK_DOWN;
        end else if (pick < 95) begin
            cmd = CMD_MARK_UP;
        end else begin
            cmd = CMD_RESERVED;
        end
        if ($urandom_range(3) == 0) begin
            idx = 4'($urandom_range(15));
        end else begin
            idx = 4'($urandom_range(pool_eff - 1));
        end
        issue_command(cmd, idx);
    endtask

    // Main sequence.
    initial begin
        int pick;
        int goal;
        logic [4:0] size_val;

        cmd_bus.valid   <= 1'b0;
        cmd_bus.payload <= '0;
        cfg_bus.valid   <= 1'b0;
        cfg_bus.payload <= '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: single-target pool after reset, including a reserved command.
        issue_command(CMD_ACQUIRE, 4'd0);
        issue_command(CMD_RESERVED, 4'd15);

        // Full pool: take down both ends, rotate the pointer, restore.
        write_pool_size(5'd16);
        issue_command(CMD_MARK_DOWN, 4'd0);
        issue_command(CMD_MARK_DOWN, 4'd15);
        repeat (6) issue_command(CMD_ACQUIRE, 4'd7);
        issue_command(CMD_MARK_UP, 4'd15);
        issue_command(CMD_MARK_UP, 4'd0);

        // Shrink the pool below the pointer, then mark a missing target and
        // empty the pool so that an acquire finds nothing.
        write_pool_size(5'd4);
        issue_command(CMD_ACQUIRE, 4'd0);
        issue_command(CMD_MARK_DOWN, 4'd9);
        for (int i = 0; i < 4; i++) begin
            issue_command(CMD_MARK_DOWN, 4'(i));
        end
        issue_command(CMD_ACQUIRE, 4'd3);
        issue_command(CMD_MARK_UP, 4'd2);
        issue_command(CMD_ACQUIRE, 4'd5);

        // A zero pool size acts as one target.
        write_pool_size(5'd0);
        issue_command(CMD_ACQUIRE, 4'd1);
        issue_command(CMD_MARK_DOWN, 4'd0);
        issue_command(CMD_ACQUIRE, 4'd0);
        issue_command(CMD_MARK_UP, 4'd0);

        // An oversized pool size saturates.
        write_pool_size(5'd31);
        issue_command(CMD_ACQUIRE, 4'd15);

        // Random phases, each with its own idling pattern and several pool sizes.
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = SEND_IDLE_PCT[phase];
            recv_stall_pct = RECV_STALL_PCT[phase];
            for (int s = 0; s < SETTINGS_PER_PHASE; s++) begin
                pick = $urandom_range(9);
                if (pick == 0) begin
                    size_val = 5'd0;
                end else if (pick == 1) begin
                    size_val = 5'($urandom_range(31, 17));
                end else if (pick == 2) begin
                    size_val = 5'd16;
                end else if (pick == 3) begin
                    size_val = 5'd1;
                end else begin
                    size_val = 5'($urandom_range(15, 2));
                end
                write_pool_size(size_val);
                goal = cmds_sent + CMDS_PER_SETTING;
                while (cmds_sent < goal) begin
                    pick = $urandom_range(99);
                    if (pick < 2) begin
                        // Take the whole pool down, then try to acquire.
                        for (int i = 0; i < pool_eff; i++) begin
                            issue_command(CMD_MARK_DOWN, 4'(i));
                        end
                        issue_command(CMD_ACQUIRE, 4'($urandom_range(15)));
                    end else if (pick < 4) begin
                        for (int i = 0; i < pool_eff; i++) begin
                            issue_command(CMD_MARK_UP, 4'(i));
                        end
                    end else if (pick < 6) begin
                        // Let the selector run dry before carrying on.
                        drain_results();
                        random_command();
                    end else begin
                        random_command();
                    end
                end
            end
        end

        drain_results();
        repeat (24) @(posedge clk);
        if (fail_count == 0 && outstanding == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rrhts_pkg.sv
rtl/rrhts_cfg_if.sv
rtl/rrhts_cmd_if.sv
rtl/rrhts_res_if.sv
rtl/rrhts_scan_unit.sv
rtl/round_robin_healthy_target_select_core.sv
tb/sv/target_select_checker.sv
tb/sv/tb.sv
